[rtl/core/phase_unwrapper_assert.svh]
// assertion helpers for the phase unwrapper
`ifndef PHASE_UNWRAPPER_ASSERT_SVH
`define PHASE_UNWRAPPER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("phase unwrapper assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define PU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("phase unwrapper assertion failed");

`endif

[rtl/core/pu_pkg.sv]
package pu_pkg;

    localparam int TURN_BITS_DEF = 16;
    localparam int OUT_WIDTH_DEF = 40;
    localparam int PHASE_IN_W    = 32;
    localparam int FRAC_W        = 16;
    localparam int COEFF_W       = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ADJ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COEFF = 2'd2;

    localparam logic [1:0] MODE_NEXT = 2'd0;
    localparam logic [1:0] MODE_TURN = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    localparam logic [COEFF_W-1:0] COEFF_RST = 16'd58982;

endpackage

[rtl/core/pu_in_if.sv]
interface pu_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pu_pkg::PHASE_IN_W-1:0]  phase_in;
    logic                                  first;

    modport source (output valid, output phase_in, output first, input ready);
    modport sink   (input valid, input phase_in, input first, output ready);
endinterface

[rtl/core/pu_out_if.sv]
interface pu_out_if #(
    parameter int OUT_WIDTH = pu_pkg::OUT_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] phase_out;
    logic                        saturated;

    modport source (output valid, output phase_out, output saturated, input ready);
    modport sink   (input valid, input phase_out, input saturated, output ready);
endinterface

[rtl/core/phase_unwrapper.sv]
// the input transaction is registered in the input stage, the result stage drives o_res
// one sample per cycle unless o_res.ready stalls the result stage; the reference update
// (unwrap, clamp and one 16-bit coefficient multiply) is combinational between the input
// and result registers; a result waiting on o_res blocks new input only while the input
// stage is full; reset (synchronous, active low) empties both stages, zeroes the reference
// and returns the configuration registers to their defaults
`include "phase_unwrapper_assert.svh"

module phase_unwrapper #(
    parameter int TURN_BITS = pu_pkg::TURN_BITS_DEF,
    parameter int OUT_WIDTH = pu_pkg::OUT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pu_in_if.sink                             i_smp,
    pu_out_if.source                          o_res
);

    localparam int PW    = pu_pkg::PHASE_IN_W;
    localparam int FW    = pu_pkg::FRAC_W;
    localparam int RI    = (OUT_WIDTH > PW) ? OUT_WIDTH : PW;
    localparam int CW    = RI + 2;
    localparam int REF_W = RI + FW;

    localparam logic signed [CW-1:0] TURN = CW'(1) <<< TURN_BITS;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    // configuration
    logic [1:0]                    r_mode;
    logic                          r_adj;
    logic [pu_pkg::COEFF_W-1:0]    r_coeff;

    // input stage, result stage, reference
    logic                          r_s1_vld;
    logic signed [PW-1:0]          r_s1_phase;
    logic                          r_s1_first;
    logic                          r_s2_vld;
    logic signed [OUT_WIDTH-1:0]   r_s2_phase;
    logic                          r_s2_sat;
    logic signed [REF_W-1:0]       r_ref;
    logic signed [REF_W-1:0]       n_ref;

    logic                          in_take;
    logic                          s1_move;

    logic [TURN_BITS-1:0]          p_low;
    logic signed [CW-1:0]          p_ext;
    logic signed [CW-1:0]          first_val;
    logic signed [CW-1:0]          ref_hi_ext;
    logic signed [CW-1:0]          r0;
    logic signed [CW-1:0]          splice;
    logic signed [CW-1:0]          val0;
    logic signed [REF_W-1:0]       refq;
    logic signed [CW-1:0]          cl_val [2];
    logic signed [CW-1:0]          val_pre;
    logic                          fits;
    logic signed [OUT_WIDTH-1:0]   val_sat;
    logic signed [REF_W-1:0]       vq;
    logic signed [REF_W:0]         ref_diff;
    logic signed [REF_W+17:0]      prod;
    logic signed [REF_W+17:0]      prod_sh;

    assign s1_move     = r_s1_vld && (!r_s2_vld || o_res.ready);
    assign i_smp.ready = !r_s1_vld || s1_move;
    assign in_take     = i_smp.valid && i_smp.ready;

    assign o_res.valid     = r_s2_vld;
    assign o_res.phase_out = r_s2_phase;
    assign o_res.saturated = r_s2_sat;

    // next-phase unwrap
    assign p_low      = r_s1_phase[TURN_BITS-1:0];
    assign p_ext      = CW'(r_s1_phase);
    // with adjust set, a negative first sample is lifted to its remainder modulo one turn
    assign first_val  = (r_adj && r_s1_phase[PW-1]) ? {{(CW-TURN_BITS){1'b0}}, p_low} : p_ext;
    assign ref_hi_ext = CW'($signed(r_ref[REF_W-1:FW]));
    assign r0         = r_s1_first ? first_val : ref_hi_ext;
    assign splice     = {r0[CW-1:TURN_BITS], p_low};

    always_comb begin
        if (p_ext >= r0) begin
            val0 = p_ext;
        end else if (p_low < r0[TURN_BITS-1:0]) begin
            val0 = splice + TURN;
        end else begin
            val0 = splice;
        end
    end

    // closest candidate, one turn (g = 0) and half a turn (g = 1)
    assign refq = r_s1_first ? {RI'(r_s1_phase), {FW{1'b0}}} : r_ref;

    for (genvar g = 0; g < 2; g++) begin : g_close
        localparam int PB = TURN_BITS - g;
        localparam int KW = RI - PB;
        localparam int DW = PB + FW + 2;
        localparam logic signed [DW-1:0] HALF = DW'(1) <<< (PB + FW - 1);

        logic signed [KW-1:0]    k;
        logic [PB+FW-1:0]        m;
        logic [PB-1:0]           pm;
        logic signed [DW-1:0]    delta;
        logic signed [KW:0]      k_adj;

        assign k     = refq[REF_W-1:PB+FW];
        assign m     = refq[PB+FW-1:0];
        assign pm    = r_s1_phase[PB-1:0];
        assign delta = $signed({2'b00, pm, {FW{1'b0}}}) - $signed({2'b00, m});

        // one period down if more than half a period above, up if below
        always_comb begin
            if (delta > HALF) begin
                k_adj = (KW+1)'(k) - (KW+1)'(1);
            end else if (delta < -HALF) begin
                k_adj = (KW+1)'(k) + (KW+1)'(1);
            end else begin
                k_adj = (KW+1)'(k);
            end
        end

        assign cl_val[g] = CW'($signed({k_adj, pm}));
    end

    always_comb begin
        case (r_mode)
            pu_pkg::MODE_NEXT: val_pre = val0;
            pu_pkg::MODE_TURN: val_pre = cl_val[0];
            default:           val_pre = cl_val[1];
        endcase
    end

    assign fits    = (&val_pre[CW-1:OUT_WIDTH-1]) || !(|val_pre[CW-1:OUT_WIDTH-1]);
    assign val_sat = fits ? val_pre[OUT_WIDTH-1:0] : (val_pre[CW-1] ? OUT_MIN : OUT_MAX);

    // ref' = o + c*(ref - o) / 2^16, floored, all in Q.16; in next-phase mode ref' = o
    assign vq       = {RI'(val_sat), {FW{1'b0}}};
    assign ref_diff = (REF_W+1)'(refq) - (REF_W+1)'(vq);
    assign prod     = ref_diff * $signed({1'b0, r_coeff});
    assign prod_sh  = prod >>> FW;

    always_comb begin
        if (r_mode == pu_pkg::MODE_NEXT) begin
            n_ref = vq;
        end else begin
            n_ref = vq + prod_sh[REF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pu_pkg::MODE_NEXT;
            r_adj    <= 1'b0;
            r_coeff  <= pu_pkg::COEFF_RST;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_ref    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pu_pkg::CFG_IDX_MODE:  r_mode  <= i_cfg_data[1:0];
                    pu_pkg::CFG_IDX_ADJ:   r_adj   <= i_cfg_data[0];
                    pu_pkg::CFG_IDX_COEFF: r_coeff <= i_cfg_data[pu_pkg::COEFF_W-1:0];
                    default: ;
                endcase
            end
            if (in_take) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_s2_vld <= 1'b1;
                r_ref    <= n_ref;
            end else if (o_res.ready) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_phase <= i_smp.phase_in;
            r_s1_first <= i_smp.first;
        end
        if (s1_move) begin
            r_s2_phase <= val_sat;
            r_s2_sat   <= !fits;
        end
    end

    `PU_ASSERT_IMPL(a_sat_at_limit, r_s2_vld && r_s2_sat, r_s2_phase == OUT_MAX || r_s2_phase == OUT_MIN)
    `PU_ASSERT_NEXT(a_ref_hold, !s1_move, $stable(r_ref))
    `PU_ASSERT_NEXT(a_ref_int_mode0, s1_move && r_mode == pu_pkg::MODE_NEXT, r_ref[FW-1:0] == '0)

endmodule
